@@ rtl/ltok_pkg.sv @@
// ----------------------------------------------------------------------------
// ltok_pkg
// Shared types, constants and result builders for the length-prefixed
// message tokenizer.
// ----------------------------------------------------------------------------
package ltok_pkg;

    localparam int MAX_FIELDS_DEF = 4;
    localparam int HDR_BYTES      = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int SLOTS          = 3;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic
    {
        EV_FIELD = 1'b0,
        EV_END   = 1'b1
    } event_t;

    typedef struct packed
    {
        event_t      kind;
        logic [1:0]  index;
        logic [31:0] start;
        logic [31:0] length;
        logic [2:0]  count;
    } result_t;

    typedef struct packed
    {
        logic [1:0]          n;
        result_t [SLOTS-1:0] slot;
    } bundle_t;

    function automatic result_t field_res(logic [1:0] idx, logic [31:0] st,
                                          logic [31:0] len);
        result_t r;
        r.kind   = EV_FIELD;
        r.index  = idx;
        r.start  = st;
        r.length = len;
        r.count  = 3'd0;
        return r;
    endfunction

    function automatic result_t end_res(logic [2:0] cnt);
        result_t r;
        r.kind   = EV_END;
        r.index  = 2'd0;
        r.start  = 32'd0;
        r.length = 32'd0;
        r.count  = cnt;
        return r;
    endfunction

endpackage

@@ rtl/ltok_front.sv @@
// ----------------------------------------------------------------------------
// ltok_front
// Accepts stream bytes, tracks header and field state, and builds a bundle
// of up to three results per byte.
// ----------------------------------------------------------------------------
module ltok_front
    import ltok_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       q_ready,
    output logic       q_push,
    output bundle_t    q_data
);

    localparam int FF_W = $clog2(MAX_FIELDS + 1);
    localparam logic [1:0] HDR_LAST = 2'(HDR_BYTES - 1);

    logic            in_header_reg, in_header_next;
    logic [1:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]     msg_len_reg, msg_len_next;
    logic [31:0]     offset_reg, offset_next;
    logic [FF_W-1:0] fields_reg, fields_next;
    logic            in_field_reg, in_field_next;
    logic            in_quotes_reg, in_quotes_next;
    logic            pending_reg, pending_next;
    logic [31:0]     cur_start_reg, cur_start_next;

    logic accept;

    assign in_ready = q_ready;
    assign accept   = in_valid & q_ready;

    always_comb
    begin
        logic [31:0]     p;
        logic            last;
        logic            consumed;
        logic [1:0]      n;
        logic [FF_W+2:0] ff_ext;
        bundle_t         b;

        in_header_next = in_header_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        msg_len_next   = msg_len_reg;
        offset_next    = offset_reg;
        fields_next    = fields_reg;
        in_field_next  = in_field_reg;
        in_quotes_next = in_quotes_reg;
        pending_next   = pending_reg;
        cur_start_next = cur_start_reg;
        p        = offset_reg;
        last     = 1'b0;
        consumed = 1'b0;
        n        = 2'd0;
        ff_ext   = '0;
        b        = '0;

        if (accept)
        begin
            if (in_header_reg)
            begin
                msg_len_next = {msg_len_reg[23:0], data_byte};
                if (hdr_cnt_reg == HDR_LAST)
                begin
                    hdr_cnt_next   = 2'd0;
                    offset_next    = 32'd0;
                    fields_next    = '0;
                    in_field_next  = 1'b0;
                    in_quotes_next = 1'b0;
                    pending_next   = 1'b0;
                    cur_start_next = 32'd0;
                    if (msg_len_next == 32'd0)
                    begin
                        b.slot[n] = end_res(3'd0);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        in_header_next = 1'b0;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            else
            begin
                last = (p + 32'd1 == msg_len_reg);
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    if (data_byte == QUOTE_CHAR)
                    begin
                        consumed = 1'b1;
                    end
                    else
                    begin
                        ff_ext = (FF_W+3)'(fields_next);
                        b.slot[n] = field_res(ff_ext[1:0], cur_start_next,
                                              (p - 32'd1) - cur_start_next);
                        n = n + 2'd1;
                        fields_next    = fields_next + FF_W'(1);
                        in_field_next  = 1'b0;
                        in_quotes_next = 1'b0;
                    end
                end
                if (!consumed && (fields_next < FF_W'(MAX_FIELDS)))
                begin
                    if (in_field_next)
                    begin
                        if ((in_quotes_next && data_byte == QUOTE_CHAR && last)
                            || (!in_quotes_next && data_byte == SPACE_CHAR))
                        begin
                            ff_ext = (FF_W+3)'(fields_next);
                            b.slot[n] = field_res(ff_ext[1:0], cur_start_next,
                                                  p - cur_start_next);
                            n = n + 2'd1;
                            fields_next    = fields_next + FF_W'(1);
                            in_field_next  = 1'b0;
                            in_quotes_next = 1'b0;
                        end
                        else if (in_quotes_next && data_byte == QUOTE_CHAR)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    else if (data_byte != SPACE_CHAR)
                    begin
                        in_field_next = 1'b1;
                        if (data_byte == QUOTE_CHAR)
                        begin
                            in_quotes_next = 1'b1;
                            cur_start_next = p + 32'd1;
                        end
                        else
                        begin
                            cur_start_next = p;
                        end
                    end
                end
                offset_next = p + 32'd1;
                if (last)
                begin
                    if (in_field_next)
                    begin
                        ff_ext = (FF_W+3)'(fields_next);
                        b.slot[n] = field_res(ff_ext[1:0], cur_start_next,
                                              msg_len_reg - cur_start_next);
                        n = n + 2'd1;
                        fields_next = fields_next + FF_W'(1);
                    end
                    ff_ext = (FF_W+3)'(fields_next);
                    b.slot[n] = end_res(ff_ext[2:0]);
                    n = n + 2'd1;
                    in_header_next = 1'b1;
                    hdr_cnt_next   = 2'd0;
                    offset_next    = 32'd0;
                    fields_next    = '0;
                    in_field_next  = 1'b0;
                    in_quotes_next = 1'b0;
                    pending_next   = 1'b0;
                    cur_start_next = 32'd0;
                end
            end
        end

        b.n    = n;
        q_data = b;
        q_push = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b1;
            hdr_cnt_reg   <= 2'd0;
            msg_len_reg   <= 32'd0;
            offset_reg    <= 32'd0;
            fields_reg    <= '0;
            in_field_reg  <= 1'b0;
            in_quotes_reg <= 1'b0;
            pending_reg   <= 1'b0;
            cur_start_reg <= 32'd0;
        end
        else
        begin
            in_header_reg <= in_header_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            msg_len_reg   <= msg_len_next;
            offset_reg    <= offset_next;
            fields_reg    <= fields_next;
            in_field_reg  <= in_field_next;
            in_quotes_reg <= in_quotes_next;
            pending_reg   <= pending_next;
            cur_start_reg <= cur_start_next;
        end
    end

endmodule

@@ rtl/ltok_queue.sv @@
// ----------------------------------------------------------------------------
// ltok_queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module ltok_queue
    import ltok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    push_ready,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/ltok_back.sv @@
// ----------------------------------------------------------------------------
// ltok_back
// Unpacks queued bundles into single results, one per cycle while out_ready
// is high and the queue is not empty, through an output register.
// ----------------------------------------------------------------------------
module ltok_back
    import ltok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_not_empty,
    input  bundle_t q_head,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic    out_last
);

    logic       valid_reg, valid_next;
    result_t    res_reg, res_next;
    logic       last_reg, last_next;
    logic [1:0] pos_reg, pos_next;
    logic       load;
    logic       at_end;

    assign load   = (!valid_reg || out_ready) && q_not_empty;
    assign at_end = (pos_reg == q_head.n - 2'd1);
    assign q_pop  = load && at_end;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = q_head.slot[pos_reg];
            last_next  = at_end;
            pos_next   = at_end ? 2'd0 : pos_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/length_prefixed_message_tokenizer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_message_tokenizer
// Splits a length-prefixed byte stream into field and message-end results.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+----
//  in      | in_valid, in_ready, data_byte                   | in
//  out     | out_valid, out_ready, event_kind, field_index,  | out
//          | field_start, field_length, field_count,         |
//          | last_of_run                                     |
//
// One byte is accepted per cycle while the bundle queue has room; each byte
// is classified in the cycle it is accepted. Results leave one per cycle from
// the output register while out_ready is high, so the results of one byte
// leave one after another. Output stalls back up through the two-entry queue
// to in_ready. Reset puts the block in header state with an empty queue.
// ----------------------------------------------------------------------------
module length_prefixed_message_tokenizer
    import ltok_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        event_kind,
    output logic [1:0]  field_index,
    output logic [31:0] field_start,
    output logic [31:0] field_length,
    output logic [2:0]  field_count,
    output logic        last_of_run
);

    logic    q_ready;
    logic    q_push;
    bundle_t q_data;
    logic    q_pop;
    logic    q_not_empty;
    bundle_t q_head;
    result_t res;

    ltok_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    ltok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    ltok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (res),
        .out_last    (last_of_run)
    );

    assign event_kind   = res.kind;
    assign field_index  = res.index;
    assign field_start  = res.start;
    assign field_length = res.length;
    assign field_count  = res.count;

endmodule
